// ===== design/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

	localparam int CP_W    = 21;
	localparam int BYTE_W  = 8;
	localparam int TDATA_W = 24;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

	// One queued word: some error results, then an optional closing result.
	typedef struct packed {
		logic [1:0]      err_cnt;   // errors for a broken sequence
		logic            fin_vld;   // closing result present
		logic            fin_err;   // closing result is a stray-byte error
		logic [CP_W-1:0] cp;        // closing code point (zero on error)
	} job_t;

endpackage

// ===== design/u8d_front.sv =====
// Front end: keeps the sequence state and turns each byte into a job.
module u8d_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic [u8d_pkg::BYTE_W-1:0] text_byte,
	output logic                       push,
	output u8d_pkg::job_t              job
);
	import u8d_pkg::*;

	logic [1:0]      need_q;
	logic [1:0]      held_q;
	logic [CP_W-1:0] part_q;

	logic [1:0]      need_d;
	logic [1:0]      held_d;
	logic [CP_W-1:0] part_d;
	logic            is_cont;

	always_comb begin
		is_cont = (text_byte & CONT_MASK) == CONT_TAG;
		need_d  = need_q;
		held_d  = held_q;
		part_d  = part_q;
		job     = '0;
		if (need_q != 2'd0 && is_cont) begin
			part_d = {part_q[CP_W-7:0], text_byte[5:0]};
			need_d = need_q - 2'd1;
			held_d = held_q + 2'd1;
			if (need_q == 2'd1) begin
				job.fin_vld = 1'b1;
				job.cp      = part_d;
				need_d      = 2'd0;
				held_d      = 2'd0;
				part_d      = '0;
			end
		end else begin
			// broken sequence: one error per byte held, then redecode as lead
			if (need_q != 2'd0)
				job.err_cnt = held_q;
			need_d = 2'd0;
			held_d = 2'd0;
			part_d = '0;
			if (text_byte == '0) begin
				// end of text: nothing more
			end else if (!text_byte[7]) begin
				job.fin_vld = 1'b1;
				job.cp      = {{(CP_W-BYTE_W){1'b0}}, text_byte};
			end else if ((text_byte & LEAD2_MASK) == LEAD2_TAG) begin
				part_d = {{(CP_W-5){1'b0}}, text_byte[4:0]};
				need_d = 2'd1;
				held_d = 2'd1;
			end else if ((text_byte & LEAD3_MASK) == LEAD3_TAG) begin
				part_d = {{(CP_W-4){1'b0}}, text_byte[3:0]};
				need_d = 2'd2;
				held_d = 2'd1;
			end else if ((text_byte & LEAD4_MASK) == LEAD4_TAG) begin
				part_d = {{(CP_W-3){1'b0}}, text_byte[2:0]};
				need_d = 2'd3;
				held_d = 2'd1;
			end else begin
				job.fin_vld = 1'b1;
				job.fin_err = 1'b1;
			end
		end
		push = acc && (job.fin_vld || job.err_cnt != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= '0;
			held_q <= '0;
			part_q <= '0;
		end else if (acc) begin
			need_q <= need_d;
			held_q <= held_d;
			part_q <= part_d;
		end
	end

endmodule

// ===== design/u8d_queue.sv =====
// Small job queue between front and back ends.
module u8d_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u8d_pkg::job_t wr_job,
	input  logic          pop,
	output u8d_pkg::job_t head,
	output logic          empty,
	output logic          full
);
	import u8d_pkg::*;

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + Q_PTR_W'(1);
			if (pop)
				rd_q <= rd_q + Q_PTR_W'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/u8d_back.sv =====
// Back end: expands jobs into results, one per cycle while the output is not stalled, into the output register.
module u8d_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  u8d_pkg::job_t            head,
	input  logic                     empty,
	output logic                     pop,
	output logic                     out_vld,
	input  logic                     out_rdy,
	output logic [u8d_pkg::CP_W-1:0] out_cp,
	output logic                     out_err,
	output logic                     out_last
);
	import u8d_pkg::*;

	logic [1:0]      done_q;
	logic            vld_q;
	logic [CP_W-1:0] cp_q;
	logic            err_q;
	logic            last_q;

	logic            load;
	logic            emit;
	logic            in_errs;
	logic            e_last;

	always_comb begin
		load    = !vld_q || out_rdy;
		emit    = load && !empty;
		in_errs = done_q != head.err_cnt;
		e_last  = in_errs ? ((done_q + 2'd1 == head.err_cnt) && !head.fin_vld) : 1'b1;
		pop     = emit && e_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			done_q <= '0;
		end else if (load) begin
			vld_q <= !empty;
			if (emit)
				done_q <= (e_last || !in_errs) ? 2'd0 : done_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q   <= in_errs ? '0 : head.cp;
			err_q  <= in_errs ? 1'b1 : head.fin_err;
			last_q <= e_last;
		end
	end

	assign out_vld  = vld_q;
	assign out_cp   = cp_q;
	assign out_err  = err_q;
	assign out_last = last_q;

endmodule

// ===== design/utf8_stream_decoder.sv =====
// Top level of the streaming UTF-8 decoder.
//
// Input channel s_*: one text byte per word in s_tdata[7:0]. A zero byte ends
// the text and flushes any pending sequence as errors.
// Output channel m_*: one result per word. m_tdata[20:0] holds the code point
// (zero for an error), m_tuser flags an error result, m_tlast marks the final
// result caused by one input byte. A byte may cause zero to four results.
// The front end decodes each byte in the cycle it is accepted and writes a job
// into a four-entry queue; the back end expands a job into its results, one
// per cycle while m_tready is high, into a registered output.
// On its way out a result is registered in the queue entry, then in the output register.
// Throughput: one byte per cycle while each byte gives at most one result
// and m_tready stays high; a broken sequence adds one extra result per held
// byte, which the queue absorbs.
// Reset clears the sequence state, empties the queue and drops m_tvalid.
// When the receiver stalls, the output word holds, the queue fills, and
// s_tready falls once all four entries are in use.
module utf8_stream_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [u8d_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [u8d_pkg::TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic                        m_tuser,   // [0] is_error
	output logic                        m_tlast    // last_of_run
);
	import u8d_pkg::*;

	logic            acc;
	logic            push;
	logic            pop;
	logic            empty;
	logic            full;
	job_t            new_job;
	job_t            head;
	logic [CP_W-1:0] cp;

	assign s_tready = !full;
	assign acc      = s_tvalid && s_tready;

	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.text_byte (s_tdata),
		.push      (push),
		.job       (new_job)
	);

	u8d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (new_job),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.out_vld  (m_tvalid),
		.out_rdy  (m_tready),
		.out_cp   (cp),
		.out_err  (m_tuser),
		.out_last (m_tlast)
	);

	assign m_tdata = {{(TDATA_W-CP_W){1'b0}}, cp};

endmodule

// ===== design/u8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module u8d_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [u8d_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tuser,
	input logic                        m_tlast
);
	import u8d_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:CP_W] == '0)
		else $error("pad bits of code point not zero");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error result carries a code point");

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
